// File: src/cir_pkg.sv
// ----------------------------------------------------------------------------
// cir_pkg
// shared types, widths and saturation helpers for the contact impulse resolver
// ----------------------------------------------------------------------------
package cir_pkg;

  localparam int REST_W  = 17;
  localparam int NORM_FB = 14;
  localparam int NUM_W   = 70;  // dividend width, delta or penetration times inverse mass
  localparam int DEN_W   = 33;  // total inverse mass
  localparam int QUO_W   = 38;  // quotient never exceeds delta
  localparam int DIV_LAT = QUO_W + 1;
  localparam int PROD_W  = 55;  // normal times quotient

  typedef struct packed {
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic [31:0]        inv_mass_a;
    logic [31:0]        inv_mass_b;
    logic               fixed_a;
    logic               fixed_b;
    logic               has_b;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [31:0] penetration;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_vel_a_x;
    logic signed [31:0] new_vel_a_y;
    logic signed [31:0] new_vel_b_x;
    logic signed [31:0] new_vel_b_y;
    logic signed [31:0] move_a_x;
    logic signed [31:0] move_a_y;
    logic signed [31:0] move_b_x;
    logic signed [31:0] move_b_y;
    logic               impulse_applied;
  } out_t;

  // classified contact passed from front to back
  typedef struct packed {
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic [31:0]        ea;
    logic [31:0]        eb;
    logic [DEN_W-1:0]   total;
    logic [QUO_W-1:0]   delta;
    logic [30:0]        pen;
    logic               do_vel;
    logic               do_pen;
    logic               has_b;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

  typedef struct packed {
    logic [2:0] inflight;
  } front_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    if (v > 42'sd2147483647) begin
      sat32 = 32'sh7fffffff;
    end else if (v < -42'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // v + floor(p / 2^14), saturated
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] v,
                                                 input logic signed [PROD_W-1:0] p);
    logic signed [41:0] s;
    s = 42'(v) + 42'($signed(p[PROD_W-1:NORM_FB]));
    sat_add = sat32(s);
  endfunction

  // v - floor(p / 2^14), saturated
  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] v,
                                                 input logic signed [PROD_W-1:0] p);
    logic signed [41:0] s;
    s = 42'(v) - 42'($signed(p[PROD_W-1:NORM_FB]));
    sat_sub = sat32(s);
  endfunction

  // +/- floor(p / 2^14), saturated
  function automatic logic signed [31:0] sat_move(input logic signed [PROD_W-1:0] p,
                                                  input logic neg);
    logic signed [41:0] s;
    s = 42'($signed(p[PROD_W-1:NORM_FB]));
    sat_move = sat32(neg ? -s : s);
  endfunction

endpackage

// File: src/cir_div.sv
// ----------------------------------------------------------------------------
// cir_div
// pipelined restoring divider, one quotient bit per stage, no stall
// ----------------------------------------------------------------------------
module cir_div (
  input  logic                     clk,
  input  logic [cir_pkg::NUM_W-1:0] num,
  input  logic [cir_pkg::DEN_W-1:0] den,
  output logic [cir_pkg::QUO_W-1:0] quo
);
  import cir_pkg::*;

  logic [DEN_W-1:0] rem_r [0:QUO_W];
  logic [QUO_W-1:0] low_r [0:QUO_W];
  logic [QUO_W-1:0] q_r   [0:QUO_W];
  logic [DEN_W-1:0] den_r [0:QUO_W];

  // upper dividend bits are already below the divisor
  always_ff @(posedge clk) begin
    rem_r[0] <= {1'b0, num[NUM_W-1:QUO_W]};
    low_r[0] <= num[QUO_W-1:0];
    q_r[0]   <= '0;
    den_r[0] <= den;
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           ge;
    assign trial = {rem_r[k], low_r[k][QUO_W-1]};
    assign ge    = trial >= {1'b0, den_r[k]};
    always_ff @(posedge clk) begin
      rem_r[k+1] <= ge ? DEN_W'(trial - {1'b0, den_r[k]}) : DEN_W'(trial);
      low_r[k+1] <= {low_r[k][QUO_W-2:0], 1'b0};
      q_r[k+1]   <= {q_r[k][QUO_W-2:0], ge};
      den_r[k+1] <= den_r[k];
    end
  end

  assign quo = q_r[QUO_W];

endmodule

// File: src/cir_front.sv
// ----------------------------------------------------------------------------
// cir_front
// accepts contacts, closing velocity, restitution scaling and classification
// ----------------------------------------------------------------------------
module cir_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  cir_pkg::in_t             in_data,
  input  logic [cir_pkg::REST_W-1:0] restitution,
  output cir_pkg::push_t           push,
  output cir_pkg::front_stat_t     stat
);
  import cir_pkg::*;

  logic               v1_r, v2_r, v3_r, v4_r;
  item_t              s1_r, s2_r, s3_r, s4_r;
  item_t              s4_nxt;
  logic               closing3_r;
  logic signed [32:0] dx1_r, dy1_r;
  logic signed [48:0] px2_r, py2_r;
  logic [35:0]        ncv3_r;

  logic signed [31:0] vbx_m, vby_m;
  logic [31:0]        ea, eb;
  logic [DEN_W-1:0]   tot;
  logic               skip, pen_pos;
  logic signed [49:0] dot;
  logic signed [35:0] cv;
  logic [53:0]        dprod;
  logic [17:0]        factor;

  always_comb begin
    vbx_m   = in_data.has_b ? in_data.vel_b_x : '0;
    vby_m   = in_data.has_b ? in_data.vel_b_y : '0;
    ea      = in_data.fixed_a ? '0 : in_data.inv_mass_a;
    eb      = (in_data.has_b && !in_data.fixed_b) ? in_data.inv_mass_b : '0;
    tot     = {1'b0, ea} + {1'b0, eb};
    skip    = (in_data.has_b && in_data.fixed_a && in_data.fixed_b) || (tot == '0);
    pen_pos = !in_data.penetration[31] && (in_data.penetration != '0);
  end

  always_ff @(posedge clk) begin
    s1_r.vax    <= in_data.vel_a_x;
    s1_r.vay    <= in_data.vel_a_y;
    s1_r.vbx    <= vbx_m;
    s1_r.vby    <= vby_m;
    s1_r.nx     <= in_data.normal_x;
    s1_r.ny     <= in_data.normal_y;
    s1_r.ea     <= ea;
    s1_r.eb     <= eb;
    s1_r.total  <= tot;
    s1_r.delta  <= '0;
    s1_r.pen    <= pen_pos ? in_data.penetration[30:0] : '0;
    s1_r.do_vel <= !skip;
    s1_r.do_pen <= !skip && pen_pos;
    s1_r.has_b  <= in_data.has_b;
    dx1_r       <= 33'(in_data.vel_a_x) - 33'(vbx_m);
    dy1_r       <= 33'(in_data.vel_a_y) - 33'(vby_m);
  end

  always_ff @(posedge clk) begin
    s2_r  <= s1_r;
    px2_r <= dx1_r * 49'(s1_r.nx);
    py2_r <= dy1_r * 49'(s1_r.ny);
  end

  always_comb begin
    dot = 50'(px2_r) + 50'(py2_r);
    cv  = dot[49:NORM_FB];
  end

  always_ff @(posedge clk) begin
    s3_r       <= s2_r;
    closing3_r <= cv[35] || (cv == '0);
    ncv3_r     <= 36'(-cv);
  end

  always_comb begin
    factor = 18'(65536) + 18'(restitution);
    dprod  = 54'(ncv3_r) * 54'(factor);
    s4_nxt        = s3_r;
    s4_nxt.delta  = dprod[53:16];
    s4_nxt.do_vel = s3_r.do_vel && closing3_r;
  end

  always_ff @(posedge clk) begin
    s4_r <= s4_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign push.valid    = v4_r;
  assign push.item     = s4_r;
  assign stat.inflight = 3'(v1_r) + 3'(v2_r) + 3'(v3_r) + 3'(v4_r);

endmodule

// File: src/cir_queue.sv
// ----------------------------------------------------------------------------
// cir_queue
// short register queue between front and back
// ----------------------------------------------------------------------------
module cir_queue #(
  parameter int DEPTH = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  cir_pkg::push_t push,
  input  logic           pop,
  output cir_pkg::push_t head,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import cir_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  item_t          mem_r [0:DEPTH-1];
  logic [PW-1:0]  wr_r, rd_r, wr_nxt, rd_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_pop;

  always_comb begin
    do_pop  = pop && (cnt_r != '0);
    wr_nxt  = (wr_r == PW'(DEPTH-1)) ? '0 : wr_r + 1'b1;
    rd_nxt  = (rd_r == PW'(DEPTH-1)) ? '0 : rd_r + 1'b1;
    cnt_nxt = cnt_r + CW'(push.valid) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_r] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push.valid) begin
        wr_r <= wr_nxt;
      end
      if (do_pop) begin
        rd_r <= rd_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign head.valid = cnt_r != '0;
  assign head.item  = mem_r[rd_r];
  assign count      = cnt_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push.valid && (cnt_r == CW'(DEPTH)) && !do_pop))
    else $error("queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue count out of range");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push.valid && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not advance");

endmodule

// File: src/cir_back.sv
// ----------------------------------------------------------------------------
// cir_back
// impulse and correction sharing by inverse mass, velocity and move update
// ----------------------------------------------------------------------------
module cir_back (
  input  logic           clk,
  input  logic           rst_n,
  input  cir_pkg::push_t head,
  output logic           out_valid,
  output cir_pkg::out_t  out_data
);
  import cir_pkg::*;

  logic              v1_r, v2_r, v3_r, ov_r;
  item_t             s1_r, s2_r, s3_r;
  logic [63:0]       dal_r, dbl_r;
  logic [37:0]       dah_r, dbh_r;
  logic [62:0]       pa1_r, pb1_r;
  logic [NUM_W-1:0]  nda_r, ndb_r, npa_r, npb_r;
  logic [QUO_W-1:0]  qda, qdb, qpa, qpb;
  item_t             dl_r [0:DIV_LAT-1];
  logic              dlv_r [0:DIV_LAT-1];
  logic signed [PROD_W-1:0] m_r [0:7];
  out_t              out_r;

  always_ff @(posedge clk) begin
    s1_r  <= head.item;
    dal_r <= 64'(head.item.delta[31:0]) * 64'(head.item.ea);
    dah_r <= 38'(head.item.delta[QUO_W-1:32]) * 38'(head.item.ea);
    dbl_r <= 64'(head.item.delta[31:0]) * 64'(head.item.eb);
    dbh_r <= 38'(head.item.delta[QUO_W-1:32]) * 38'(head.item.eb);
    pa1_r <= 63'(head.item.pen) * 63'(head.item.ea);
    pb1_r <= 63'(head.item.pen) * 63'(head.item.eb);
  end

  always_ff @(posedge clk) begin
    s2_r  <= s1_r;
    nda_r <= NUM_W'(dal_r) + {dah_r, 32'b0};
    ndb_r <= NUM_W'(dbl_r) + {dbh_r, 32'b0};
    npa_r <= NUM_W'(pa1_r);
    npb_r <= NUM_W'(pb1_r);
  end

  cir_div u_div_da (.clk(clk), .num(nda_r), .den(s2_r.total), .quo(qda));
  cir_div u_div_db (.clk(clk), .num(ndb_r), .den(s2_r.total), .quo(qdb));
  cir_div u_div_pa (.clk(clk), .num(npa_r), .den(s2_r.total), .quo(qpa));
  cir_div u_div_pb (.clk(clk), .num(npb_r), .den(s2_r.total), .quo(qpb));

  // sideband delay matched to divider latency
  always_ff @(posedge clk) begin
    dl_r[0] <= s2_r;
    for (int i = 1; i < DIV_LAT; i++) begin
      dl_r[i] <= dl_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        dlv_r[i] <= 1'b0;
      end
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      v1_r     <= head.valid;
      v2_r     <= v1_r;
      dlv_r[0] <= v2_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        dlv_r[i] <= dlv_r[i-1];
      end
      v3_r <= dlv_r[DIV_LAT-1];
      ov_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_r   <= dl_r[DIV_LAT-1];
    m_r[0] <= PROD_W'(dl_r[DIV_LAT-1].nx) * $signed({1'b0, qda});
    m_r[1] <= PROD_W'(dl_r[DIV_LAT-1].ny) * $signed({1'b0, qda});
    m_r[2] <= PROD_W'(dl_r[DIV_LAT-1].nx) * $signed({1'b0, qdb});
    m_r[3] <= PROD_W'(dl_r[DIV_LAT-1].ny) * $signed({1'b0, qdb});
    m_r[4] <= PROD_W'(dl_r[DIV_LAT-1].nx) * $signed({1'b0, qpa});
    m_r[5] <= PROD_W'(dl_r[DIV_LAT-1].ny) * $signed({1'b0, qpa});
    m_r[6] <= PROD_W'(dl_r[DIV_LAT-1].nx) * $signed({1'b0, qpb});
    m_r[7] <= PROD_W'(dl_r[DIV_LAT-1].ny) * $signed({1'b0, qpb});
  end

  always_ff @(posedge clk) begin
    if (s3_r.do_vel) begin
      out_r.new_vel_a_x <= sat_add(s3_r.vax, m_r[0]);
      out_r.new_vel_a_y <= sat_add(s3_r.vay, m_r[1]);
      out_r.new_vel_b_x <= sat_sub(s3_r.vbx, m_r[2]);
      out_r.new_vel_b_y <= sat_sub(s3_r.vby, m_r[3]);
    end else begin
      out_r.new_vel_a_x <= s3_r.vax;
      out_r.new_vel_a_y <= s3_r.vay;
      out_r.new_vel_b_x <= s3_r.vbx;
      out_r.new_vel_b_y <= s3_r.vby;
    end
    if (s3_r.do_pen) begin
      out_r.move_a_x <= sat_move(m_r[4], 1'b0);
      out_r.move_a_y <= sat_move(m_r[5], 1'b0);
      out_r.move_b_x <= sat_move(m_r[6], 1'b1);
      out_r.move_b_y <= sat_move(m_r[7], 1'b1);
    end else begin
      out_r.move_a_x <= '0;
      out_r.move_a_y <= '0;
      out_r.move_b_x <= '0;
      out_r.move_b_y <= '0;
    end
    out_r.impulse_applied <= s3_r.do_vel;
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

  a_no_pen_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !s3_r.do_pen) |=> (out_r.move_a_x == '0 && out_r.move_b_y == '0))
    else $error("move without penetration");

  a_absent_b: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !s3_r.has_b) |=> (out_r.new_vel_b_x == '0 && out_r.new_vel_b_y == '0))
    else $error("absent second body has velocity");

  a_applied_flag: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |=> (out_r.impulse_applied == $past(s3_r.do_vel)))
    else $error("impulse flag mismatch");

endmodule

// File: src/contact_impulse_resolver.sv
// ----------------------------------------------------------------------------
// contact_impulse_resolver
// resolves one 2D contact per cycle into new velocities and position moves
// ----------------------------------------------------------------------------
// one contact may be started every cycle while busy is low; each contact
// gives exactly one result, shown on out_data for a single cycle with
// out_valid high, in start order. between the start and result transfers a
// contact passes through 4 front stages, the queue, 2 product stages, the
// 39-stage divider pipeline that splits impulse and penetration by inverse
// mass, and 2 update stages. the receiver cannot stall, so the back end drains
// the queue every cycle and busy only rises if the queue plus front stages
// could overfill. the block does not enforce this rule: the user must write
// restitution through cfg_we/cfg_wdata only while no contact is in flight
// ----------------------------------------------------------------------------
module contact_impulse_resolver #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  cir_pkg::in_t          in_data,
  output logic                  out_valid,
  output cir_pkg::out_t         out_data,
  input  logic                  cfg_we,
  input  logic [16:0]           cfg_wdata
);
  import cir_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH+1);

  logic [REST_W-1:0] rest_r;
  logic              accept;
  push_t             push, head;
  front_stat_t       fstat;
  logic [CW-1:0]     qcount;
  logic [CW:0]       pending;

  // restitution register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r <= '0;
    end else if (cfg_we) begin
      rest_r <= cfg_wdata;
    end
  end

  // hold off new transfers only when the queue could not absorb the front
  assign pending = (CW+1)'(qcount) + (CW+1)'(fstat.inflight);
  assign busy    = pending >= (CW+1)'(QUEUE_DEPTH);
  assign accept  = start && !busy;

  cir_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_data     (in_data),
    .restitution (rest_r),
    .push        (push),
    .stat        (fstat)
  );

  cir_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (1'b1),
    .head  (head),
    .count (qcount)
  );

  cir_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: bench/tb_contact_impulse_resolver.sv
// ----------------------------------------------------------------------------
// tb_contact_impulse_resolver
// self-checking bench: directed and random contacts against a contact predictor
// ----------------------------------------------------------------------------
// each start transfer is run through a bit-exact predictor of the impulse and
// penetration split; the expected result is queued and compared field by field
// with every out_valid strobe. restitution is changed between phases, only
// after the result queue has drained and the pipeline has had time to settle
// ----------------------------------------------------------------------------
module tb_contact_impulse_resolver;
  timeunit 1ns;
  timeprecision 1ps;
  import cir_pkg::*;

  localparam int LATENCY   = 48;
  localparam int MAX_CYCLE = 400000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_t         in_data;
  logic        out_valid;
  out_t        out_data;
  logic        cfg_we;
  logic [16:0] cfg_wdata;

  // predictor copy of the restitution register
  logic [16:0] rest_q;
  out_t        resolved_q[$];
  int          err_cnt;
  int          cyc;
  int          idle_gap_max;

  contact_impulse_resolver u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // floor division by 2^14 on a wide signed value
  function automatic logic signed [127:0] fshr14(input logic signed [127:0] v);
    fshr14 = v >>> NORM_FB;
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) begin
      clip32 = 32'sh7fffffff;
    end else if (v < -128'sd2147483648) begin
      clip32 = 32'sh80000000;
    end else begin
      clip32 = v[31:0];
    end
  endfunction

  // new velocities and moves for one contact
  function automatic out_t resolve_contact(input in_t c, input logic [16:0] rest);
    out_t r;
    logic signed [127:0] vax, vay, vbx, vby, nx, ny, cv, sa, sb, pa, pb;
    logic [127:0] ea, eb, tot, delta;
    vax = c.vel_a_x; vay = c.vel_a_y; vbx = c.vel_b_x; vby = c.vel_b_y;
    nx  = c.normal_x; ny = c.normal_y;
    if (!c.has_b) begin
      vbx = 0;
      vby = 0;
    end
    r = '0;
    r.new_vel_a_x = c.vel_a_x;
    r.new_vel_a_y = c.vel_a_y;
    r.new_vel_b_x = vbx[31:0];
    r.new_vel_b_y = vby[31:0];
    if (!(c.has_b && c.fixed_a && c.fixed_b)) begin
      ea  = c.fixed_a ? 128'd0 : 128'(c.inv_mass_a);
      eb  = (c.has_b && !c.fixed_b) ? 128'(c.inv_mass_b) : 128'd0;
      tot = ea + eb;
      if (tot != 0) begin
        cv = fshr14((vax - vbx) * nx + (vay - vby) * ny);
        if (cv <= 0) begin
          delta = (128'(-cv) * (128'd65536 + 128'(rest))) >> 16;
          sa = (delta * ea) / tot;
          sb = (delta * eb) / tot;
          r.new_vel_a_x = clip32(vax + fshr14(nx * sa));
          r.new_vel_a_y = clip32(vay + fshr14(ny * sa));
          if (c.has_b) begin
            r.new_vel_b_x = clip32(vbx - fshr14(nx * sb));
            r.new_vel_b_y = clip32(vby - fshr14(ny * sb));
          end
          r.impulse_applied = 1'b1;
        end
        if (c.penetration > 0) begin
          pa = (128'(c.penetration) * ea) / tot;
          pb = (128'(c.penetration) * eb) / tot;
          r.move_a_x = clip32(fshr14(nx * pa));
          r.move_a_y = clip32(fshr14(ny * pa));
          r.move_b_x = clip32(-fshr14(nx * pb));
          r.move_b_y = clip32(-fshr14(ny * pb));
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cyc);
    err_cnt++;
  endtask

  // result checker, one compare per strobe
  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid) begin
      if (resolved_q.size() == 0) begin
        report_mismatch("unexpected result", 32'd0, 32'd0);
      end else begin
        e = resolved_q.pop_front();
        if (out_data.new_vel_a_x !== e.new_vel_a_x)
          report_mismatch("new_vel_a_x", out_data.new_vel_a_x, e.new_vel_a_x);
        if (out_data.new_vel_a_y !== e.new_vel_a_y)
          report_mismatch("new_vel_a_y", out_data.new_vel_a_y, e.new_vel_a_y);
        if (out_data.new_vel_b_x !== e.new_vel_b_x)
          report_mismatch("new_vel_b_x", out_data.new_vel_b_x, e.new_vel_b_x);
        if (out_data.new_vel_b_y !== e.new_vel_b_y)
          report_mismatch("new_vel_b_y", out_data.new_vel_b_y, e.new_vel_b_y);
        if (out_data.move_a_x !== e.move_a_x)
          report_mismatch("move_a_x", out_data.move_a_x, e.move_a_x);
        if (out_data.move_a_y !== e.move_a_y)
          report_mismatch("move_a_y", out_data.move_a_y, e.move_a_y);
        if (out_data.move_b_x !== e.move_b_x)
          report_mismatch("move_b_x", out_data.move_b_x, e.move_b_x);
        if (out_data.move_b_y !== e.move_b_y)
          report_mismatch("move_b_y", out_data.move_b_y, e.move_b_y);
        if (out_data.impulse_applied !== e.impulse_applied)
          report_mismatch("impulse_applied", 32'(out_data.impulse_applied),
                          32'(e.impulse_applied));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > MAX_CYCLE) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one start transfer; start stays high across back-to-back items
  task automatic send_contact(input in_t c);
    start   <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    resolved_q.push_back(resolve_contact(c, rest_q));
  endtask

  task automatic idle_line(input int n);
    if (n > 0) begin
      start <= 1'b0;
      in_data <= in_t'(($bits(in_t))'({$urandom, $urandom, $urandom, $urandom,
                                        $urandom, $urandom, $urandom, $urandom,
                                        $urandom}));
      repeat (n) @(posedge clk);
    end
  endtask

  // wait for every result plus pipeline settle, then write restitution
  task automatic set_restitution(input logic [16:0] v);
    idle_line(1);
    while (resolved_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    rest_q = v;
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 7))
      0: pick32 = 32'h7fffffff;
      1: pick32 = 32'h80000000;
      2: pick32 = 32'(int'($urandom_range(0, 2 << 16)) - (1 << 16));
      3: pick32 = 32'(int'($urandom_range(0, 200 << 16)) - (100 << 16));
      default: pick32 = $urandom;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_norm();
    case ($urandom_range(0, 5))
      0: pick_norm = 16'sd16384;
      1: pick_norm = -16'sd16384;
      2: pick_norm = 16'sd0;
      3: pick_norm = 16'($urandom);
      default: pick_norm = 16'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic in_t rand_contact();
    in_t c;
    c.vel_a_x = pick32();
    c.vel_a_y = pick32();
    c.vel_b_x = pick32();
    c.vel_b_y = pick32();
    c.inv_mass_a = ($urandom_range(0, 3) == 0) ? pick32() : 32'($urandom_range(0, 8 << 16));
    c.inv_mass_b = ($urandom_range(0, 3) == 0) ? pick32() : 32'($urandom_range(0, 8 << 16));
    c.fixed_a = ($urandom_range(0, 4) == 0);
    c.fixed_b = ($urandom_range(0, 4) == 0);
    c.has_b   = ($urandom_range(0, 4) != 0);
    c.normal_x = pick_norm();
    c.normal_y = pick_norm();
    c.penetration = pick32();
    return c;
  endfunction

  function automatic in_t base_contact();
    in_t c;
    c = '0;
    c.vel_a_x    = -32'sd65536;
    c.vel_b_x    = 32'sd65536;
    c.inv_mass_a = 32'd65536;
    c.inv_mass_b = 32'd131072;
    c.has_b      = 1'b1;
    c.normal_x   = 16'sd16384;
    c.penetration = 32'sd32768;
    return c;
  endfunction

  task automatic test_directed();
    in_t c;
    send_contact(base_contact());
    c = base_contact(); c.has_b = 1'b0; send_contact(c);
    c = base_contact(); c.fixed_a = 1'b1; c.fixed_b = 1'b1; send_contact(c);
    c = base_contact(); c.fixed_a = 1'b1; send_contact(c);
    c = base_contact(); c.fixed_b = 1'b1; send_contact(c);
    c = base_contact(); c.vel_a_x = 32'sd65536; c.vel_b_x = -32'sd65536; send_contact(c);
    c = base_contact(); c.inv_mass_a = 0; c.inv_mass_b = 0; send_contact(c);
    c = base_contact(); c.vel_a_x = 0; c.vel_b_x = 0; send_contact(c);
    c = base_contact(); c.penetration = -32'sd5; send_contact(c);
    c = base_contact(); c.normal_x = 16'sh8000; c.normal_y = 16'sd32767; send_contact(c);
    c = base_contact(); c.vel_a_x = 32'sh80000000; c.vel_b_x = 32'sh7fffffff;
    c.inv_mass_a = 32'hffffffff; c.inv_mass_b = 32'hffffffff; send_contact(c);
    c = base_contact(); c.vel_a_y = 32'sh7fffffff; c.vel_b_y = 32'sh80000000;
    c.normal_x = 0; c.normal_y = -16'sd16384; c.penetration = 32'sh7fffffff; send_contact(c);
    c = base_contact(); c.has_b = 1'b0; c.fixed_a = 1'b1; send_contact(c);
    c = '1; send_contact(c);
    c = '0; send_contact(c);
  endtask

  task automatic test_random(input int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && n > 0) begin
        send_contact(rand_contact());
        burst--;
        n--;
      end
      if ($urandom_range(0, 2) != 0) idle_line($urandom_range(1, idle_gap_max));
    end
  endtask

  initial begin
    rst_n = 1'b0; start = 1'b0; in_data = '0; cfg_we = 1'b0; cfg_wdata = '0;
    rest_q = '0; err_cnt = 0; cyc = 0; idle_gap_max = 6;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of restitution first
    test_directed();
    set_restitution(17'd65536);
    test_directed();
    test_random(300);
    set_restitution(17'd0);
    test_random(250);
    set_restitution(17'($urandom_range(1, 65535)));
    idle_gap_max = 60;
    test_random(250);
    set_restitution(17'h1ffff);
    idle_gap_max = 3;
    test_random(250);

    idle_line(1);
    while (resolved_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
src/cir_pkg.sv
src/cir_div.sv
src/cir_front.sv
src/cir_queue.sv
src/cir_back.sv
src/contact_impulse_resolver.sv
bench/tb_contact_impulse_resolver.sv
